// ----- hw/rtl/prologue_instruction_length_decode_defines.svh -----
// assertion macros for the instruction length decoder checker
// used by pild_checker; expects clk_i and rst_ni in scope
`ifndef PROLOGUE_INSTRUCTION_LENGTH_DECODE_DEFINES_SVH
`define PROLOGUE_INSTRUCTION_LENGTH_DECODE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PILD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication with a delayed consequent given as a sequence
`define PILD_ASSERT_SEQ(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

// ----- hw/rtl/pild_pkg.sv -----
// types and opcode constants for the instruction length decoder
// no dependencies
`timescale 1ns / 1ps

package pild_pkg;

  // prefix and opcode bytes
  localparam logic [7:0] PfxOpSize  = 8'h66;
  localparam logic [3:0] RexHigh    = 4'h4;
  localparam logic [7:0] OpEscape   = 8'h0F;
  localparam logic [7:0] OpNopLong  = 8'h1F;
  localparam logic [7:0] OpGrp1Ib   = 8'h83;
  localparam logic [7:0] OpGrp1Iz   = 8'h81;
  localparam logic [7:0] OpNop      = 8'h90;
  localparam logic [4:0] OpMovImmHi = 5'b10111;
  localparam logic [3:0] OpPushPop  = 4'h5;
  localparam logic [7:0] OpTest8    = 8'h84;
  localparam logic [7:0] OpTest     = 8'h85;
  localparam logic [7:0] OpLea      = 8'h8D;
  localparam logic [7:0] OpGrp4     = 8'hFE;
  localparam logic [7:0] OpGrp5     = 8'hFF;
  localparam logic [5:0] OpMovRmHi  = 6'b100010;

  // modrm mode field values
  localparam logic [1:0] ModIndir  = 2'd0;
  localparam logic [1:0] ModDisp8  = 2'd1;
  localparam logic [1:0] ModDisp32 = 2'd2;
  localparam logic [1:0] ModReg    = 2'd3;
  localparam logic [2:0] RmSib     = 3'd4;
  localparam logic [2:0] RmRipRel  = 3'd5;

  // one decode request
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [4:0] available_bytes;
  } inst_t;

  // one decode result
  typedef struct packed {
    logic [3:0] length;
    logic       rip_relative;
    logic [2:0] disp_offset;
  } res_t;

endpackage

// ----- hw/rtl/pild_decode.sv -----
// combinational length decode of one instruction from its first five bytes
// depends on pild_pkg
`timescale 1ns / 1ps

module pild_decode (
  input  pild_pkg::inst_t req_i,
  output pild_pkg::res_t  rsp_o
);

  // byte select by index
  function automatic logic [7:0] pick(input pild_pkg::inst_t r, input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0:    v = r.byte0;
      3'd1:    v = r.byte1;
      3'd2:    v = r.byte2;
      3'd3:    v = r.byte3;
      3'd4:    v = r.byte4;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  logic [4:0] avail;
  logic       opsz;
  logic [2:0] rex_idx;
  logic [7:0] rex_byte;
  logic       rex;
  logic       wide;
  logic [2:0] op_idx;
  logic       op_ok;
  logic [7:0] op;
  logic [2:0] nxt_idx;
  logic       esc_ok;
  logic       is_simple;
  logic       is_movimm;
  logic       is_alu;
  logic       has_modrm;
  logic [4:0] imm;
  logic [2:0] mrm_idx;
  logic [7:0] mrm;
  logic [1:0] mode;
  logic [2:0] rm;
  logic       sib;
  logic       sib_bad;
  logic       rip;
  logic [4:0] span;
  logic [4:0] len;
  logic       ok;
  logic       rip_ok;

  assign avail = req_i.available_bytes;

  // prefixes: optional operand size, then optional rex
  assign opsz     = (req_i.byte0 == pild_pkg::PfxOpSize);
  assign rex_idx  = opsz ? 3'd1 : 3'd0;
  assign rex_byte = opsz ? req_i.byte1 : req_i.byte0;
  assign rex      = ({2'b00, rex_idx} < avail) && (rex_byte[7:4] == pild_pkg::RexHigh);
  assign wide     = rex && rex_byte[3];

  // opcode byte and the byte after it
  assign op_idx  = rex_idx + {2'b00, rex};
  assign op_ok   = ({2'b00, op_idx} < avail);
  assign op      = pick(req_i, op_idx);
  assign nxt_idx = op_idx + 3'd1;
  assign esc_ok  = (op == pild_pkg::OpEscape) && ({2'b00, nxt_idx} < avail)
                   && (pick(req_i, nxt_idx) == pild_pkg::OpNopLong);

  // opcode classes
  assign is_simple = (op[7:4] == pild_pkg::OpPushPop) || (op == pild_pkg::OpNop);
  assign is_movimm = (op[7:3] == pild_pkg::OpMovImmHi);
  assign is_alu    = (op[7:6] == 2'b00) && !op[2] && (op[5:4] != 2'b01);

  always_comb begin
    has_modrm = 1'b1;
    imm       = 5'd0;
    if (is_alu || op == pild_pkg::OpTest8 || op == pild_pkg::OpTest
        || op[7:2] == pild_pkg::OpMovRmHi || op == pild_pkg::OpLea
        || op == pild_pkg::OpGrp4 || op == pild_pkg::OpGrp5) begin
      imm = 5'd0;
    end else if (op == pild_pkg::OpGrp1Ib) begin
      imm = 5'd1;
    end else if (op == pild_pkg::OpGrp1Iz) begin
      imm = (opsz && !wide) ? 5'd2 : 5'd4;
    end else if (esc_ok) begin
      imm = 5'd0;
    end else begin
      has_modrm = 1'b0;
    end
  end

  // modrm byte and the sib / displacement bytes it implies
  assign mrm_idx = esc_ok ? (nxt_idx + 3'd1) : nxt_idx;
  assign mrm     = pick(req_i, mrm_idx);
  assign mode    = mrm[7:6];
  assign rm      = mrm[2:0];
  assign sib_bad = (mode == pild_pkg::ModIndir) && (rm == pild_pkg::RmSib);
  assign sib     = (mode != pild_pkg::ModReg) && (rm == pild_pkg::RmSib);
  assign rip     = (mode == pild_pkg::ModIndir) && (rm == pild_pkg::RmRipRel);

  always_comb begin
    span = 5'd1 + {4'd0, sib};
    unique case (mode)
      pild_pkg::ModIndir:  span = span + (rip ? 5'd4 : 5'd0);
      pild_pkg::ModDisp8:  span = span + 5'd1;
      pild_pkg::ModDisp32: span = span + 5'd4;
      pild_pkg::ModReg:    span = 5'd1;
      default:             span = 5'd1;
    endcase
  end

  // total length and the acceptance decision
  always_comb begin
    len = 5'd0;
    ok  = 1'b0;
    if (op_ok) begin
      priority if (is_simple) begin
        len = {2'b00, nxt_idx};
        ok  = 1'b1;
      end else if (is_movimm) begin
        len = {2'b00, nxt_idx} + (wide ? 5'd8 : (opsz ? 5'd2 : 5'd4));
        ok  = (len <= avail);
      end else if (has_modrm) begin
        len = {2'b00, mrm_idx} + span + imm;
        ok  = ({2'b00, mrm_idx} < avail) && !sib_bad && (len <= avail);
      end else begin
        ok  = 1'b0;
      end
    end
  end

  // rip-relative flag only on an accepted modrm form
  assign rip_ok = ok && !is_simple && !is_movimm && rip;

  assign rsp_o.length       = ok ? len[3:0] : 4'd0;
  assign rsp_o.rip_relative = rip_ok;
  assign rsp_o.disp_offset  = rip_ok ? (mrm_idx + 3'd1) : 3'd0;

endmodule

// ----- hw/rtl/prologue_instruction_length_decode.sv -----
// Instruction length decoder for a restricted x86-64 prologue subset.
//
// Request channel: drive req_i (five instruction bytes and the count of
// readable bytes) with start_i high; the request is taken at a rising edge
// where start_i is high and busy_o is low. busy_o is always low, so a new
// request can be taken at every clock edge.
// Result channel: done_o is high for exactly one cycle with rsp_o holding
// the length (0 when refused or truncated), the rip-relative flag and the
// offset of its disp32.
// Path: the request is registered in the input register at the accepting
// edge, decoded by one combinational pass and registered again in the result
// register; done_o is high while the result register holds the new result.
// Throughput: one request per cycle, set by the single registered decode pass.
// The receiver cannot stall; results are dropped onto the port without waiting.
// Reset: rst_ni low clears both valid flags at once; no result appears
// until a request has been taken after reset.
// depends on pild_pkg and pild_decode
`timescale 1ns / 1ps

module prologue_instruction_length_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  pild_pkg::inst_t req_i,
  output logic            done_o,
  output pild_pkg::res_t  rsp_o
);

  logic            in_vld_q;
  logic            in_vld_d;
  pild_pkg::inst_t in_q;
  pild_pkg::res_t  res_d;
  pild_pkg::res_t  res_q;
  logic            out_vld_q;

  // never blocks
  assign busy_o   = 1'b0;
  assign in_vld_d = start_i && !busy_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_d) begin
      in_q <= req_i;
    end
  end

  // decode pass
  pild_decode u_decode (
    .req_i (in_q),
    .rsp_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = out_vld_q;
  assign rsp_o  = res_q;

endmodule

// ----- hw/rtl/pild_checker.sv -----
// port-level checks for the instruction length decoder, bound to the top level
// depends on pild_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "prologue_instruction_length_decode_defines.svh"

module pild_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           done_o,
  input pild_pkg::res_t rsp_o
);

  logic taken;
  logic refused;
  logic no_disp;
  logic rip_hit;
  logic disp_ok;

  // terms used by the checks below
  assign taken   = start_i && !busy_o;
  assign refused = done_o && (rsp_o.length == 4'd0);
  assign no_disp = !rsp_o.rip_relative && (rsp_o.disp_offset == 3'd0);
  assign rip_hit = done_o && rsp_o.rip_relative;
  assign disp_ok = (rsp_o.disp_offset != 3'd0) && (rsp_o.length > 4'(rsp_o.disp_offset));

  // every taken request gives a result once it has passed the input and result registers
  `PILD_ASSERT_SEQ(a_req_gives_done, taken, ##2 done_o, "request lost")

  // no result without a request taken ahead of it through the input and result registers
  `PILD_ASSERT_SEQ(a_no_spurious_done, !taken, ##2 !done_o, "result invented")

  // refused results carry no rip-relative info
  `PILD_ASSERT_NOW(a_refused_clean, refused, no_disp, "refusal with displacement")

  // rip-relative disp32 offset is nonzero and starts inside the instruction
  `PILD_ASSERT_NOW(a_rip_in_range, rip_hit, disp_ok, "bad disp offset")

endmodule

bind prologue_instruction_length_decode pild_checker u_pild_checker (.*);

// ----- sim/pild_length_checker.sv -----
// checker for the instruction length decoder: predicts each decode request
// and compares every result against the oldest prediction; needs pild_pkg
`timescale 1ns / 1ps

module pild_length_checker
  import pild_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  busy_i,
  input  inst_t req_i,
  input  logic  done_i,
  input  res_t  rsp_i,
  output int    error_count_o,
  output int    pending_o
);

  res_t expected_decodes[$];
  res_t want;
  int   mismatch_count;
  int   pending_count;

  assign error_count_o = mismatch_count;
  assign pending_o     = pending_count;

  // length, rip flag and disp32 offset of one request
  function automatic res_t predict_length(inst_t req);
    logic [7:0]  b [5];
    logic [7:0]  op;
    logic [7:0]  modrm;
    int unsigned avail;
    int unsigned pos;
    int unsigned imm;
    int unsigned span;
    int unsigned len;
    bit          opsz;
    bit          wide;
    bit          has_modrm;
    bit          rip;
    res_t        res;
    b[0]      = req.byte0;
    b[1]      = req.byte1;
    b[2]      = req.byte2;
    b[3]      = req.byte3;
    b[4]      = req.byte4;
    avail     = req.available_bytes;
    res       = '0;
    pos       = 0;
    imm       = 0;
    opsz      = 1'b0;
    wide      = 1'b0;
    has_modrm = 1'b0;
    rip       = 1'b0;
    if (avail == 0) return res;
    // optional operand-size prefix, then optional rex
    if (b[0] == PfxOpSize) begin
      opsz = 1'b1;
      pos  = 1;
    end
    if (pos < avail && b[pos][7:4] == RexHigh) begin
      wide = b[pos][3];
      pos++;
    end
    if (pos >= avail) return res;
    op = b[pos];
    pos++;
    // one-byte forms need no more bytes
    if (op[7:4] == OpPushPop || op == OpNop) begin
      res.length = 4'(pos);
      return res;
    end
    // mov r, imm: imm64 with rex.w, imm16 with 0x66, else imm32
    if (op[7:3] == OpMovImmHi) begin
      len = pos + (wide ? 8 : (opsz ? 2 : 4));
      if (len <= avail) res.length = 4'(len);
      return res;
    end
    // alu forms: 00-03, 08-0b, 20-23, 28-2b, 30-33, 38-3b
    if ((op[7:6] == 2'b00 && op[5:4] != 2'b01 && !op[2]) || op[7:2] == OpMovRmHi ||
        op == OpTest8 || op == OpTest || op == OpLea || op == OpGrp4 || op == OpGrp5) begin
      has_modrm = 1'b1;
    end else if (op == OpGrp1Ib) begin
      has_modrm = 1'b1;
      imm       = 1;
    end else if (op == OpGrp1Iz) begin
      has_modrm = 1'b1;
      imm       = (opsz && !wide) ? 2 : 4;
    end else if (op == OpEscape && pos < avail && b[pos & 3] == OpNopLong) begin
      pos++;
      has_modrm = 1'b1;
    end
    if (!has_modrm || pos >= avail || pos > 4) return res;
    // modrm, sib and displacement bytes
    modrm = b[pos];
    span  = 1;
    if (modrm[7:6] != ModReg) begin
      if (modrm[2:0] == RmSib) begin
        if (modrm[7:6] == ModIndir) return res;
        span++;
      end
      if (modrm[7:6] == ModIndir) begin
        if (modrm[2:0] == RmRipRel) begin
          rip  = 1'b1;
          span += 4;
        end
      end else if (modrm[7:6] == ModDisp8) begin
        span += 1;
      end else begin
        span += 4;
      end
    end
    len = pos + span + imm;
    if (len > avail) return res;
    res.length = 4'(len);
    if (rip) begin
      res.rip_relative = 1'b1;
      res.disp_offset  = 3'(pos + 1);
    end
    return res;
  endfunction

  // compare results in order, then queue the prediction for a new request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_decodes.delete();
      mismatch_count = 0;
      pending_count  = 0;
    end else begin
      if (done_i) begin
        if (expected_decodes.size() == 0) begin
          $error("result with no request waiting: length %0d", rsp_i.length);
          mismatch_count++;
        end else begin
          want = expected_decodes.pop_front();
          if (rsp_i.length !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, rsp_i.length);
            mismatch_count++;
          end
          if (rsp_i.rip_relative !== want.rip_relative) begin
            $error("rip_relative: expected %0d, actual %0d",
                   want.rip_relative, rsp_i.rip_relative);
            mismatch_count++;
          end
          if (rsp_i.disp_offset !== want.disp_offset) begin
            $error("disp_offset: expected %0d, actual %0d",
                   want.disp_offset, rsp_i.disp_offset);
            mismatch_count++;
          end
        end
      end
      if (start_i && !busy_i) expected_decodes.push_back(predict_length(req_i));
      pending_count = expected_decodes.size();
    end
  end

endmodule

// ----- sim/tb_prologue_instruction_length_decode.sv -----
// testbench top for the instruction length decoder: drives directed and
// random decode requests and reports the verdict
// needs pild_pkg, pild_length_checker and prologue_instruction_length_decode
`timescale 1ns / 1ps

module tb_prologue_instruction_length_decode
  import pild_pkg::*;
;

  localparam int         StallLimit     = 1000;
  localparam int         RandomPerPhase = 410;
  localparam logic [7:0] RexW           = {RexHigh, 4'h8};
  localparam logic [7:0] PfxRep         = 8'hF3;
  localparam logic [7:0] OpUd2Tail      = 8'h0B;
  localparam logic [7:0] PushRbp        = {OpPushPop, 4'h5};
  localparam logic [7:0] MovStore       = {OpMovRmHi, 2'b01};
  localparam logic [7:0] MovLoad        = {OpMovRmHi, 2'b11};
  localparam logic [7:0] MovImm         = {OpMovImmHi, 3'd0};
  localparam logic [7:0] RmRegRbpRsp    = {ModReg, 3'd4, 3'd5};
  localparam logic [7:0] RmRegSubRsp    = {ModReg, 3'd5, 3'd4};
  localparam logic [7:0] RmRegAddRax    = {ModReg, 3'd0, 3'd0};
  localparam logic [7:0] RmRip          = {ModIndir, 3'd0, RmRipRel};
  localparam logic [7:0] RmSibIndir     = {ModIndir, 3'd0, RmSib};
  localparam logic [7:0] RmSibDisp8     = {ModDisp8, 3'd0, RmSib};
  localparam logic [7:0] RmSibDisp32    = {ModDisp32, 3'd0, RmSib};

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  start_i;
  logic  busy_o;
  inst_t req_i;
  logic  done_o;
  res_t  rsp_o;
  int    error_count;
  int    pending_decodes;
  int    stall_cycles;
  int    idle_pct [3] = '{11, 68, 0};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  prologue_instruction_length_decode dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  pild_length_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .req_i         (req_i),
    .done_i        (done_o),
    .rsp_i         (rsp_o),
    .error_count_o (error_count),
    .pending_o     (pending_decodes)
  );

  // watchdog on cycles with no request and no result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("tb_prologue_instruction_length_decode: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // hold off at random, then present one request until it is taken
  task automatic send_request(input inst_t req, input int unsigned pct);
    while ($urandom_range(0, 99) < pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= req;
    do @(posedge clk_i); while (busy_o);
  endtask

  // mostly well-formed instructions with random content, some noise
  function automatic inst_t random_request();
    logic [7:0]  b [5];
    int unsigned pos;
    int unsigned sel;
    inst_t       req;
    for (int k = 0; k < 5; k++) b[k] = 8'($urandom);
    pos = 0;
    if ($urandom_range(0, 3) == 0) begin
      b[0] = PfxOpSize;
      pos  = 1;
    end
    if ($urandom_range(0, 1) == 0) begin
      b[pos] = {RexHigh, 4'($urandom)};
      pos++;
    end
    case ($urandom_range(0, 9))
      0: b[pos] = {OpPushPop, 4'($urandom)};
      1: b[pos] = OpNop;
      2: b[pos] = {OpMovImmHi, 3'($urandom)};
      3: begin
        b[pos] = {2'b00, 6'($urandom)};
        if (b[pos][5:4] == 2'b01) b[pos][5] = 1'b1;
        b[pos][2] = 1'b0;
      end
      4: begin
        sel = $urandom_range(0, 5);
        case (sel)
          0: b[pos] = {OpMovRmHi, 2'($urandom)};
          1: b[pos] = OpTest8;
          2: b[pos] = OpTest;
          3: b[pos] = OpLea;
          4: b[pos] = OpGrp4;
          default: b[pos] = OpGrp5;
        endcase
      end
      5: b[pos] = OpGrp1Ib;
      6: b[pos] = OpGrp1Iz;
      7: begin
        b[pos] = OpEscape;
        pos++;
        if ($urandom_range(0, 7) != 0) b[pos] = OpNopLong;
      end
      default: ;
    endcase
    pos++;
    // steer the modrm toward rip-relative and refused sib forms
    if (pos < 5) begin
      case ($urandom_range(0, 7))
        0, 1: b[pos] = {ModIndir, 3'($urandom), RmRipRel};
        2: b[pos] = {ModIndir, 3'($urandom), RmSib};
        default: ;
      endcase
    end
    req.byte0 = b[0];
    req.byte1 = b[1];
    req.byte2 = b[2];
    req.byte3 = b[3];
    req.byte4 = b[4];
    sel = $urandom_range(0, 9);
    if (sel < 7) req.available_bytes = 5'($urandom_range(1, 14));
    else if (sel < 9) req.available_bytes = 5'($urandom_range(0, 31));
    else req.available_bytes = 5'($urandom_range(0, pos));
    return req;
  endfunction

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed requests: extremes, several opcode families, refusals, truncation
    send_request({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 5'd0}, idle_pct[0]);
    send_request({OpNop, 8'h00, 8'h00, 8'h00, 8'h00, 5'd1}, idle_pct[0]);
    send_request({PushRbp, 8'h00, 8'h00, 8'h00, 8'h00, 5'd1}, idle_pct[0]);
    send_request({PfxOpSize, OpNop, 8'h00, 8'h00, 8'h00, 5'd1}, idle_pct[0]);
    send_request({RexW, OpNop, 8'h00, 8'h00, 8'h00, 5'd1}, idle_pct[0]);
    send_request({RexW, MovImm, 8'hFF, 8'hFF, 8'hFF, 5'd10}, idle_pct[0]);
    send_request({RexW, MovImm, 8'hFF, 8'hFF, 8'hFF, 5'd9}, idle_pct[0]);
    send_request({PfxOpSize, RexW, MovImm, 8'h00, 8'h00, 5'd11}, idle_pct[0]);
    send_request({PfxOpSize, MovImm, 8'h34, 8'h12, 8'h00, 5'd4}, idle_pct[0]);
    send_request({MovImm, 8'h00, 8'h00, 8'h00, 8'h00, 5'd5}, idle_pct[0]);
    send_request({RexW, MovStore, RmRegRbpRsp, 8'h00, 8'h00, 5'd3}, idle_pct[0]);
    send_request({RexW, MovLoad, RmRip, 8'h10, 8'h00, 5'd7}, idle_pct[0]);
    send_request({PfxOpSize, RexW, OpLea, RmRip, 8'h20, 5'd8}, idle_pct[0]);
    send_request({OpEscape, OpNopLong, RmSibDisp8, 8'h00, 8'h00, 5'd5}, idle_pct[0]);
    send_request({OpEscape, OpNopLong, RmSibIndir, 8'h00, 8'h00, 5'd16}, idle_pct[0]);
    send_request({PfxOpSize, OpEscape, OpNopLong, RmSibDisp32, 8'h00, 5'd9}, idle_pct[0]);
    send_request({OpEscape, OpUd2Tail, 8'h00, 8'h00, 8'h00, 5'd16}, idle_pct[0]);
    send_request({RexW, OpGrp1Ib, RmRegSubRsp, 8'h28, 8'h00, 5'd4}, idle_pct[0]);
    send_request({RexW, OpGrp1Iz, RmRegSubRsp, 8'h00, 8'h01, 5'd7}, idle_pct[0]);
    send_request({PfxOpSize, OpGrp1Iz, RmRegAddRax, 8'h00, 8'h00, 5'd5}, idle_pct[0]);
    send_request({PfxOpSize, RexW, OpGrp1Iz, RmSibDisp32, 8'h00, 5'd31}, idle_pct[0]);
    send_request({OpGrp5, RmRegAddRax, 8'h00, 8'h00, 8'h00, 5'd31}, idle_pct[0]);
    send_request({PfxRep, OpNop, 8'h00, 8'h00, 8'h00, 5'd16}, idle_pct[0]);
    send_request({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd31}, idle_pct[0]);
    send_request({OpTest, RmRip, 8'h00, 8'h00, 8'h00, 5'd5}, idle_pct[0]);

    // random requests in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < RandomPerPhase; n++) begin
        send_request(random_request(), idle_pct[phase]);
      end
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    // drain outstanding results, then allow the pipeline to settle
    while (pending_decodes != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_prologue_instruction_length_decode: clean");
    end else begin
      $display("tb_prologue_instruction_length_decode: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pild_pkg.sv
hw/rtl/pild_decode.sv
hw/rtl/prologue_instruction_length_decode.sv
hw/rtl/pild_checker.sv
sim/pild_length_checker.sv
sim/tb_prologue_instruction_length_decode.sv
